FILE: hw/rtl/pbnr_pkg.sv
// Shared types and constants for the palette blend and nearest-color remap block.
package pbnr_pkg;

  localparam int IdxW   = 8;
  localparam int CompW  = 8;
  localparam int ColorW = 3 * CompW;
  localparam int DistW  = 18;
  localparam int LimW   = 15;

  localparam int DefPaletteDepth  = 256;
  localparam int DefSearchEntries = 127;

  localparam logic [LimW-1:0] DistLimit     = 15'h7fff;
  localparam logic [IdxW-1:0] ZeroIndex     = 8'd0;
  localparam logic [IdxW-1:0] UnmappedIndex = 8'd255;

  // configuration register indexes
  localparam logic RegTarget = 1'b0;
  localparam logic RegWeight = 1'b1;

  // input action codes
  localparam logic ActLoad    = 1'b0;
  localparam logic ActCompute = 1'b1;

  typedef struct packed {
    logic load;      // write one palette entry
    logic start;     // latch a compute transaction
    logic rd_src;    // read source entry
    logic rd_tgt;    // read target entry
    logic cap_src;   // capture source read data
    logic blend;     // blend with target read data
    logic srch;      // issue one search read
    logic out_load;  // move result into output register
  } pbnr_cmd_t;

  typedef struct packed {
    logic special;    // incoming index is zero or unmapped
    logic srch_last;  // search counter at last entry
    logic out_free;   // output register can take a result
  } pbnr_sts_t;

endpackage

FILE: hw/rtl/pbnr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbnr_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/pbnr_ctrl.sv
// Controller state machine sequencing load, blend, search and result hand-off.
module pbnr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                action_i,
  output logic                in_ready_o,
  input  pbnr_pkg::pbnr_sts_t sts_i,
  output pbnr_pkg::pbnr_cmd_t cmd_o
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SSrc    = 3'd1;
  localparam logic [2:0] STgt    = 3'd2;
  localparam logic [2:0] SBlend  = 3'd3;
  localparam logic [2:0] SSrch   = 3'd4;
  localparam logic [2:0] SDrain1 = 3'd5;
  localparam logic [2:0] SDrain2 = 3'd6;
  localparam logic [2:0] SDone   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (accept && action_i == pbnr_pkg::ActLoad) begin
          cmd_o.load = 1'b1;
        end else if (accept) begin
          cmd_o.start = 1'b1;
          state_d = sts_i.special ? SDone : SSrc;
        end
      end
      SSrc: begin
        cmd_o.rd_src = 1'b1;
        state_d = STgt;
      end
      STgt: begin
        cmd_o.rd_tgt  = 1'b1;
        cmd_o.cap_src = 1'b1;
        state_d = SBlend;
      end
      SBlend: begin
        cmd_o.blend = 1'b1;
        state_d = SSrch;
      end
      SSrch: begin
        cmd_o.srch = 1'b1;
        if (sts_i.srch_last) begin
          state_d = SDrain1;
        end
      end
      SDrain1: state_d = SDrain2;
      SDrain2: state_d = SDone;
      SDone: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/pbnr_dp.sv
// Datapath: config registers, palette RAM, blend, distance pipeline, output register.
module pbnr_dp #(
  parameter int PALETTE_DEPTH  = pbnr_pkg::DefPaletteDepth,
  parameter int SEARCH_ENTRIES = pbnr_pkg::DefSearchEntries
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [pbnr_pkg::CompW-1:0]  cfg_wdata_i,
  input  logic [pbnr_pkg::IdxW-1:0]   color_index_i,
  input  logic [pbnr_pkg::CompW-1:0]  red_i,
  input  logic [pbnr_pkg::CompW-1:0]  green_i,
  input  logic [pbnr_pkg::CompW-1:0]  blue_i,
  input  pbnr_pkg::pbnr_cmd_t         cmd_i,
  output pbnr_pkg::pbnr_sts_t         sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pbnr_pkg::IdxW-1:0]   remapped_index_o,
  output logic                        mapped_o
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int IW = pbnr_pkg::IdxW;
  localparam int CW = pbnr_pkg::ColorW;

  function automatic logic [7:0] blend_comp(input logic [7:0] a, input logic [7:0] t,
                                            input logic [7:0] w);
    logic signed [8:0]  diff;
    logic signed [8:0]  wt;
    logic signed [17:0] prod;
    diff = $signed({1'b0, a}) - $signed({1'b0, t});
    wt   = $signed({1'b0, w[7:1], 1'b0});
    prod = diff * wt;
    // floor divide by 256 is an arithmetic shift; only the low byte matters
    return a - prod[15:8];
  endfunction

  function automatic logic [15:0] sq_diff(input logic [7:0] e, input logic [7:0] b);
    logic signed [8:0]  d;
    logic signed [17:0] p;
    d = $signed({1'b0, e}) - $signed({1'b0, b});
    p = d * d;
    return p[15:0];
  endfunction

  function automatic logic out_of_range(input logic [IW-1:0] a);
    return {1'b0, a} >= (IW+1)'(PALETTE_DEPTH);
  endfunction

  // config
  logic [7:0] target_q, weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      weight_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == pbnr_pkg::RegTarget) target_q <= cfg_wdata_i;
      if (cfg_index_i == pbnr_pkg::RegWeight) weight_q <= cfg_wdata_i;
    end
  end

  // palette RAM
  logic [IW-1:0] raddr;
  logic          re;
  logic [CW-1:0] rdata, rdata_eff;
  logic          rd_oob_q;
  logic [IW-1:0] idx_q, cnt_q;

  assign re = cmd_i.rd_src || cmd_i.rd_tgt || cmd_i.srch;

  always_comb begin
    raddr = cnt_q;
    if (cmd_i.rd_src) raddr = idx_q;
    if (cmd_i.rd_tgt) raddr = target_q;
  end

  pbnr_ram #(
    .Width(CW),
    .Depth(PALETTE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load && !out_of_range(color_index_i)),
    .waddr_i(color_index_i[AW-1:0]),
    .wdata_i({red_i, green_i, blue_i}),
    .re_i   (re),
    .raddr_i(raddr[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (re) rd_oob_q <= out_of_range(raddr);
  end

  assign rdata_eff = rd_oob_q ? '0 : rdata;

  // blend
  logic [CW-1:0] src_q, blended_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_src) src_q <= rdata_eff;
    if (cmd_i.blend) begin
      blended_q <= {blend_comp(src_q[23:16], rdata_eff[23:16], weight_q),
                    blend_comp(src_q[15:8],  rdata_eff[15:8],  weight_q),
                    blend_comp(src_q[7:0],   rdata_eff[7:0],   weight_q)};
    end
  end

  // search pipeline: issue, square, accumulate/compare
  logic          v1_q, v2_q;
  logic [IW-1:0] x1_q, x2_q;
  logic [15:0]   sq_r_q, sq_g_q, sq_b_q;
  logic [pbnr_pkg::DistW-1:0] dist_sum;
  logic [pbnr_pkg::LimW-1:0]  limit_q;
  logic [IW-1:0] best_q;
  logic          found_q, map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.srch && (cnt_q != idx_q);
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) cnt_q <= 8'd1;
    else if (cmd_i.srch) cnt_q <= cnt_q + 8'd1;
    x1_q   <= cnt_q;
    x2_q   <= x1_q;
    sq_r_q <= sq_diff(rdata_eff[23:16], blended_q[23:16]);
    sq_g_q <= sq_diff(rdata_eff[15:8],  blended_q[15:8]);
    sq_b_q <= sq_diff(rdata_eff[7:0],   blended_q[7:0]);
  end

  assign dist_sum = pbnr_pkg::DistW'(sq_r_q) + pbnr_pkg::DistW'(sq_g_q)
                  + pbnr_pkg::DistW'(sq_b_q);

  logic special_zero, special_unmapped;
  assign special_zero     = (color_index_i == pbnr_pkg::ZeroIndex);
  assign special_unmapped = (color_index_i == pbnr_pkg::UnmappedIndex);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      idx_q   <= color_index_i;
      best_q  <= (special_zero || special_unmapped) ? '0 : target_q;
      map_q   <= !special_unmapped;
      limit_q <= pbnr_pkg::DistLimit;
      found_q <= 1'b0;
    end else if (v2_q && !found_q) begin
      if (dist_sum == '0) begin
        best_q  <= x2_q;
        found_q <= 1'b1;
      end else if (dist_sum <= {3'b000, limit_q}) begin
        best_q  <= x2_q;
        limit_q <= dist_sum[pbnr_pkg::LimW-1:0];
      end
    end
  end

  // output register
  logic          out_valid_q;
  logic [IW-1:0] out_idx_q;
  logic          out_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q <= best_q;
      out_map_q <= map_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign remapped_index_o = out_idx_q;
  assign mapped_o         = out_map_q;

  assign sts_o.special   = special_zero || special_unmapped;
  assign sts_o.srch_last = (cnt_q == IW'(SEARCH_ENTRIES));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

FILE: hw/rtl/palette_blend_nearest_remap.sv
// Top level: palette blend toward a target color, then nearest-color search.
// Load transaction: written to the palette at accept; ready is not dropped.
// Compute transaction: read source and target, blend, then search with one palette read
// and compare per cycle; no new input is taken until the result is handed off.
// Index zero and the unmapped index skip straight to the hand-off. A held result
// stalls the next compute at its hand-off. Reset clears control and config, not the palette.
module palette_blend_nearest_remap #(
  parameter int PALETTE_DEPTH  = pbnr_pkg::DefPaletteDepth,
  parameter int SEARCH_ENTRIES = pbnr_pkg::DefSearchEntries
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [pbnr_pkg::CompW-1:0] cfg_wdata_i,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [pbnr_pkg::IdxW-1:0]  color_index_i,
  input  logic [pbnr_pkg::CompW-1:0] red_i,
  input  logic [pbnr_pkg::CompW-1:0] green_i,
  input  logic [pbnr_pkg::CompW-1:0] blue_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pbnr_pkg::IdxW-1:0]  remapped_index_o,
  output logic                       mapped_o
);

  // controller drives the datapath through one command bundle, status comes back
  pbnr_pkg::pbnr_cmd_t cmd;
  pbnr_pkg::pbnr_sts_t sts;

  pbnr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .action_i  (action_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath: palette RAM, blend stage, 3-stage distance pipeline, output register
  pbnr_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .SEARCH_ENTRIES(SEARCH_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .color_index_i   (color_index_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .remapped_index_o(remapped_index_o),
    .mapped_o        (mapped_o)
  );

endmodule
